// ===== src/text_packet_deframer_top_assert.svh =====
// Assertion macros for the text packet deframer.
// Included by the top level, the module that carries the concurrent assertions; clocked on clk_i, reset by rst_ni.
`ifndef TEXT_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define TEXT_PACKET_DEFRAMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define TPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPD_ASSERT(lbl, prop, msg)
`define TPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/tpd_pkg.sv =====
// Shared types, constants and helper functions for the text packet deframer.
// No dependencies; used by the parser, the result register, the top level and the testbench.
package tpd_pkg;

  // ASCII codes that frame the packet.
  localparam logic [7:0] ASCII_SLASH = 8'h2F;
  localparam logic [7:0] ASCII_ONE   = 8'h31;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;

  // Configuration register indexes.
  localparam logic CFG_UNDEFINED_TYPE = 1'b0;
  localparam logic CFG_TYPE_LIMIT     = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] UNDEFINED_TYPE_RESET = 8'd0;
  localparam logic [7:0] TYPE_LIMIT_RESET     = 8'd16;

  // Final packet status.
  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_TOO_SHORT      = 2'd1,
    STATUS_LEN_MISMATCH   = 2'd2,
    STATUS_COUNT_MISMATCH = 2'd3
  } status_e;

  // One result transaction.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] field_index;
    logic        field_first;
    logic        packet_done;
    logic        packet_ok;
    status_e     status_code;
    logic [7:0]  packet_kind;
    logic [15:0] fields_seen;
  } result_t;

  // Decimal accumulate: acc * 10 + digit, saturating at all ones.
  function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [3:0] digit);
    logic [35:0] wide;
    wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, digit};
    mul10_add = (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  // Map a parsed type into the accepted range or onto the undefined code.
  function automatic logic [7:0] resolve_kind(input logic [31:0] v,
                                              input logic [7:0]  undef_type,
                                              input logic [7:0]  type_limit);
    if ((v >= {24'd0, undef_type}) && (v < {24'd0, type_limit})) begin
      resolve_kind = v[7:0];
    end else begin
      resolve_kind = undef_type;
    end
  endfunction

endpackage

// ===== src/tpd_in_stage.sv =====
// Input register of the deframer: holds one accepted byte transaction.
// Depends on nothing but the clock and reset.
module tpd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       advance_i,
  output logic       s1_valid_o,
  output logic [7:0] s1_byte_o,
  output logic       s1_last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       accept;

  // The register frees up whenever its transaction moves on in this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;
  assign s1_last_o  = last_q;

endmodule

// ===== src/tpd_parser.sv =====
// Per-byte parse step of the deframer: phase register, counters and status logic.
// Depends on tpd_pkg for constants, the result struct and helper functions.
module tpd_parser #(
  parameter int LENGTH_DIGITS    = 32,
  parameter int FIELD_INDEX_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic [7:0]      undef_type_i,
  input  logic [7:0]      type_limit_i,
  output logic            res_valid_o,
  output tpd_pkg::result_t res_o
);
  import tpd_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_COUNT = 3'd1,
    PH_TYPE  = 3'd2,
    PH_SIZE  = 3'd3,
    PH_DATA  = 3'd4
  } phase_e;

  localparam int          IDX_W    = (FIELD_INDEX_BITS < 16) ? FIELD_INDEX_BITS : 16;
  localparam logic [15:0] IDX_MASK = 16'((32'd1 << IDX_W) - 32'd1);
  localparam logic [31:0] LEN_LAST = 32'(LENGTH_DIGITS - 1);
  localparam logic [31:0] LEN_MIN  = 32'(LENGTH_DIGITS);

  phase_e      phase_q, phase_d;
  logic [31:0] bytes_q, bytes_d;
  logic [31:0] dlen_q, dlen_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] dfields_q, dfields_d;
  logic [15:0] fcount_q, fcount_d;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  kind_q, kind_d;
  logic        stop_q, stop_d;
  logic        open_q, open_d;
  logic        first_q, first_d;

  logic        is_digit, is_slash;
  logic [31:0] feed_acc;
  logic        feed_stop;
  logic        pv, pfirst;
  logic [15:0] pindex;
  logic [31:0] dfields_post;
  logic [7:0]  kind_post, kind_out;
  status_e     status;

  assign is_digit = (byte_i >= ASCII_ZERO) && (byte_i <= ASCII_NINE);
  assign is_slash = (byte_i == ASCII_SLASH);

  // Decimal digit feed: the first non-digit freezes the number.
  always_comb begin
    feed_acc  = acc_q;
    feed_stop = stop_q;
    if (!stop_q) begin
      if (is_digit) begin
        feed_acc = mul10_add(acc_q, 4'(byte_i - ASCII_ZERO));
      end else begin
        feed_stop = 1'b1;
      end
    end
  end

  // Next state for one byte, then the end-of-packet status and rearm.
  always_comb begin
    phase_d   = phase_q;
    dlen_d    = dlen_q;
    acc_d     = acc_q;
    dfields_d = dfields_q;
    fcount_d  = fcount_q;
    remain_d  = remain_q;
    kind_d    = kind_q;
    stop_d    = stop_q;
    open_d    = open_q;
    first_d   = first_q;
    pv        = 1'b0;
    pfirst    = 1'b0;
    pindex    = 16'd0;
    bytes_d   = (bytes_q == 32'hFFFF_FFFF) ? bytes_q : bytes_q + 32'd1;

    case (phase_q)
      PH_LEN: begin
        dlen_d = {dlen_q[30:0], (byte_i == ASCII_ONE)};
        if (bytes_q >= LEN_LAST) begin
          phase_d = PH_COUNT;
          acc_d   = 32'd0;
          stop_d  = 1'b0;
        end
      end
      PH_COUNT: begin
        if (is_slash) begin
          dfields_d = acc_q;
          phase_d   = PH_TYPE;
          acc_d     = 32'd0;
          stop_d    = 1'b0;
        end else begin
          acc_d  = feed_acc;
          stop_d = feed_stop;
        end
      end
      PH_TYPE: begin
        if (is_slash) begin
          kind_d  = resolve_kind(acc_q, undef_type_i, type_limit_i);
          phase_d = PH_SIZE;
          open_d  = 1'b0;
          acc_d   = 32'd0;
          stop_d  = 1'b0;
        end else begin
          acc_d  = feed_acc;
          stop_d = feed_stop;
        end
      end
      PH_SIZE: begin
        // A field is counted on the first byte of its size header.
        if (!open_q) begin
          open_d = 1'b1;
          if (fcount_q != 16'hFFFF) begin
            fcount_d = fcount_q + 16'd1;
          end
        end
        if (is_slash) begin
          open_d   = 1'b0;
          remain_d = acc_q;
          if (acc_q != 32'd0) begin
            phase_d = PH_DATA;
            first_d = 1'b1;
          end
          acc_d  = 32'd0;
          stop_d = 1'b0;
        end else begin
          acc_d  = feed_acc;
          stop_d = feed_stop;
        end
      end
      default: begin
        pv       = 1'b1;
        pfirst   = first_q;
        first_d  = 1'b0;
        pindex   = (fcount_q - 16'd1) & IDX_MASK;
        remain_d = remain_q - 32'd1;
        if (remain_d == 32'd0) begin
          phase_d = PH_SIZE;
          open_d  = 1'b0;
          acc_d   = 32'd0;
          stop_d  = 1'b0;
        end
      end
    endcase

    // A packet that ends inside the header takes its numbers from the digits so far.
    dfields_post = dfields_d;
    kind_post    = kind_d;
    if (phase_d == PH_COUNT) begin
      dfields_post = acc_d;
      kind_post    = resolve_kind(32'd0, undef_type_i, type_limit_i);
    end else if (phase_d == PH_TYPE) begin
      kind_post = resolve_kind(acc_d, undef_type_i, type_limit_i);
    end

    kind_out = kind_post;
    if (bytes_d <= LEN_MIN) begin
      status   = STATUS_TOO_SHORT;
      kind_out = undef_type_i;
    end else if (bytes_d != dlen_d) begin
      status   = STATUS_LEN_MISMATCH;
      kind_out = undef_type_i;
    end else if ({16'd0, fcount_d} != dfields_post) begin
      status = STATUS_COUNT_MISMATCH;
    end else begin
      status = STATUS_OK;
    end

    // Result transaction, fields zero where they do not apply.
    res_o               = '0;
    res_o.payload_valid = pv;
    res_o.field_first   = pfirst;
    res_o.field_index   = pindex;
    res_o.payload_byte  = pv ? byte_i : 8'd0;
    if (last_i) begin
      res_o.packet_done = 1'b1;
      res_o.packet_ok   = (status == STATUS_OK);
      res_o.status_code = status;
      res_o.packet_kind = kind_out;
      res_o.fields_seen = fcount_d;
    end
    res_valid_o = step_i && (pv || last_i);

    // Rearm for the next packet after its final byte.
    if (last_i) begin
      phase_d   = PH_LEN;
      bytes_d   = 32'd0;
      dlen_d    = 32'd0;
      dfields_d = 32'd0;
      fcount_d  = 16'd0;
      remain_d  = 32'd0;
      kind_d    = undef_type_i;
      open_d    = 1'b0;
      first_d   = 1'b0;
      acc_d     = 32'd0;
      stop_d    = 1'b0;
    end
  end

  // Parse state, advanced once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      bytes_q   <= 32'd0;
      dlen_q    <= 32'd0;
      acc_q     <= 32'd0;
      dfields_q <= 32'd0;
      fcount_q  <= 16'd0;
      remain_q  <= 32'd0;
      kind_q    <= UNDEFINED_TYPE_RESET;
      stop_q    <= 1'b0;
      open_q    <= 1'b0;
      first_q   <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bytes_q   <= bytes_d;
      dlen_q    <= dlen_d;
      acc_q     <= acc_d;
      dfields_q <= dfields_d;
      fcount_q  <= fcount_d;
      remain_q  <= remain_d;
      kind_q    <= kind_d;
      stop_q    <= stop_d;
      open_q    <= open_d;
      first_q   <= first_d;
    end
  end

endmodule

// ===== src/tpd_out_stage.sv =====
// Result register of the deframer: holds one result transaction until it is taken.
// Depends on tpd_pkg for the result struct.
module tpd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  tpd_pkg::result_t res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             free_o,
  output tpd_pkg::result_t res_o
);
  import tpd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // A new result may enter when the register is empty or being drained.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = res_valid_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== src/text_packet_deframer_top.sv =====
// Top level of the text packet deframer: input register, parse step, result register.
// Depends on tpd_pkg, tpd_in_stage, tpd_parser, tpd_out_stage and the assertion header.

// The deframer takes one packet byte per clock cycle, since each byte needs a single parse
// step that updates the phase register and a few counters. That rate holds as long as the
// result side takes each result transaction when it is offered; a full result register that
// is not being drained holds every byte back, whether or not that byte has a result. A
// byte's result, if it has one, goes from the input register through the parse step, which
// loads the result register. Only payload bytes and the final byte of a packet produce a
// result; the final one carries the packet status. Configuration writes take effect at once
// and are meant for idle periods. No clearing pass is needed after reset.
module text_packet_deframer_top #(
  parameter int LENGTH_DIGITS    = 32,
  parameter int FIELD_INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] field_index_o,
  output logic        field_first_o,
  output logic        packet_done_o,
  output logic        packet_ok_o,
  output logic [1:0]  status_code_o,
  output logic [7:0]  packet_kind_o,
  output logic [15:0] fields_seen_o
);
  import tpd_pkg::*;

`include "text_packet_deframer_top_assert.svh"

  logic       s1_valid, s1_last, step, out_free, res_valid;
  logic [7:0] s1_byte;
  logic [7:0] undef_type_q, type_limit_q;
  result_t    res, res_out;
  logic       has_content, ok_consistent;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      undef_type_q <= UNDEFINED_TYPE_RESET;
      type_limit_q <= TYPE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_UNDEFINED_TYPE: undef_type_q <= cfg_data_i;
        CFG_TYPE_LIMIT:     type_limit_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  // A byte is processed when the result register can take whatever it produces.
  assign step = s1_valid && out_free;

  tpd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .advance_i   (step),
    .s1_valid_o  (s1_valid),
    .s1_byte_o   (s1_byte),
    .s1_last_o   (s1_last)
  );

  tpd_parser #(
    .LENGTH_DIGITS    (LENGTH_DIGITS),
    .FIELD_INDEX_BITS (FIELD_INDEX_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (s1_byte),
    .last_i       (s1_last),
    .undef_type_i (undef_type_q),
    .type_limit_i (type_limit_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  tpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .res_o       (res_out)
  );

  assign payload_valid_o = res_out.payload_valid;
  assign payload_byte_o  = res_out.payload_byte;
  assign field_index_o   = res_out.field_index;
  assign field_first_o   = res_out.field_first;
  assign packet_done_o   = res_out.packet_done;
  assign packet_ok_o     = res_out.packet_ok;
  assign status_code_o   = res_out.status_code;
  assign packet_kind_o   = res_out.packet_kind;
  assign fields_seen_o   = res_out.fields_seen;

  // Conditions checked by the assertions below.
  assign has_content   = !out_valid_o || payload_valid_o || packet_done_o;
  assign ok_consistent = !(out_valid_o && packet_ok_o) ||
                         (packet_done_o && status_code_o == STATUS_OK);

  // Every result transaction carries a payload byte or a packet status.
  `TPD_ASSERT(a_result_has_content, has_content, "empty result transaction")
  // An empty result register never holds back the input side.
  `TPD_ASSERT(a_ready_when_drained, out_valid_o || in_ready_o, "input stalled with empty output")
  // An ok flag only comes with a finished packet whose status code is ok.
  `TPD_ASSERT(a_ok_consistent, ok_consistent, "ok flag without ok status")
  // An accepted byte is held in the input register in the next cycle.
  `TPD_ASSERT_NEXT(a_accept_loads, in_valid_i && in_ready_o, s1_valid, "accepted byte lost")

endmodule

// ===== verif/tb.sv =====
// Testbench for text_packet_deframer_top: directed packets and random packets,
// with every result transaction checked against an in-bench predictor.
// Depends on tpd_pkg and the RTL of the block; needs no files or arguments.
module tb;
  import tpd_pkg::*;

  localparam int LenDigits   = 32;
  localparam int IdxBits     = 16;
  localparam int RandomBytes = 170;
  // A byte without a result can still sit in the two-stage pipeline when the queue runs dry.
  localparam int DrainCycles = 6;

  typedef enum logic [2:0] {PH_LEN, PH_COUNT, PH_TYPE, PH_SIZE, PH_DATA} phase_e;
  typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} ready_mode_e;

  // One directed packet: configuration, body text and, where obvious, the final status.
  typedef struct {
    logic [7:0] undef_type;
    logic [7:0] type_limit;
    bit         raw;
    int         len_delta;
    string      text;
    bit         has_exp;
    status_e    exp_status;
    logic [7:0] exp_kind;
  } packet_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = CFG_UNDEFINED_TYPE;
  logic [7:0]  cfg_data_i  = 8'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic [15:0] field_index_o;
  logic        field_first_o;
  logic        packet_done_o;
  logic        packet_ok_o;
  logic [1:0]  status_code_o;
  logic [7:0]  packet_kind_o;
  logic [15:0] fields_seen_o;

  text_packet_deframer_top #(
    .LENGTH_DIGITS   (LenDigits),
    .FIELD_INDEX_BITS(IdxBits)
  ) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Predictor state: configuration copy and the parser registers.
  logic [7:0]  cfg_undef;
  logic [7:0]  cfg_limit;
  phase_e      ph;
  logic [31:0] seen;
  logic [31:0] decl_len;
  logic [31:0] acc;
  logic [31:0] decl_fields;
  logic [31:0] remain;
  logic [15:0] fields;
  logic [7:0]  kind;
  bit          stopped;
  bit          hdr_open;
  bit          first_due;
  status_e     last_status;
  logic [7:0]  last_kind;

  result_t     deframed_q[$];
  logic [7:0]  pkt[$];
  packet_row_t rows[$];

  int errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_cfg = 0;
  int burst_left = 0;
  int status_cnt[4];

  function automatic void report_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic string show(result_t r);
    return $sformatf("pv=%0b byte=%02h idx=%0d first=%0b done=%0b ok=%0b st=%0d kind=%0d seen=%0d",
                     r.payload_valid, r.payload_byte, r.field_index, r.field_first,
                     r.packet_done, r.packet_ok, r.status_code, r.packet_kind, r.fields_seen);
  endfunction

  // Types inside [undefined_type, type_limit) pass; everything else maps to undefined_type.
  function automatic logic [7:0] kind_of(logic [31:0] v);
    return (v >= {24'd0, cfg_undef} && v < {24'd0, cfg_limit}) ? v[7:0] : cfg_undef;
  endfunction

  function automatic void restart_number();
    acc     = 32'd0;
    stopped = 1'b0;
  endfunction

  // Decimal digits accumulate with saturation until the first non-digit.
  function automatic void take_digit(logic [7:0] b);
    logic [35:0] wide;
    if (stopped) return;
    if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
      wide = {4'd0, acc} * 36'd10 + {32'd0, b[3:0]};
      acc  = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    end else begin
      stopped = 1'b1;
    end
  endfunction

  function automatic void rearm();
    ph          = PH_LEN;
    seen        = 32'd0;
    decl_len    = 32'd0;
    decl_fields = 32'd0;
    fields      = 16'd0;
    remain      = 32'd0;
    kind        = cfg_undef;
    hdr_open    = 1'b0;
    first_due   = 1'b0;
    restart_number();
  endfunction

  // Advance the parser by one accepted byte and queue the result it causes, if any.
  function automatic void deframe_byte(logic [7:0] b, logic last);
    result_t r;
    status_e st;
    r = '0;
    case (ph)
      PH_LEN: begin
        decl_len = {decl_len[30:0], b == ASCII_ONE};
        if (seen + 32'd1 >= LenDigits) begin
          ph = PH_COUNT;
          restart_number();
        end
      end
      PH_COUNT: begin
        if (b == ASCII_SLASH) begin
          decl_fields = acc;
          ph = PH_TYPE;
          restart_number();
        end else begin
          take_digit(b);
        end
      end
      PH_TYPE: begin
        if (b == ASCII_SLASH) begin
          kind     = kind_of(acc);
          ph       = PH_SIZE;
          hdr_open = 1'b0;
          restart_number();
        end else begin
          take_digit(b);
        end
      end
      PH_SIZE: begin
        // A field counts from the first byte of its size header.
        if (!hdr_open) begin
          hdr_open = 1'b1;
          if (fields != 16'hFFFF) fields++;
        end
        if (b == ASCII_SLASH) begin
          hdr_open = 1'b0;
          remain   = acc;
          if (remain != 32'd0) begin
            ph        = PH_DATA;
            first_due = 1'b1;
          end
          restart_number();
        end else begin
          take_digit(b);
        end
      end
      default: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.field_index   = fields - 16'd1;
        r.field_first   = first_due;
        first_due = 1'b0;
        remain--;
        if (remain == 32'd0) begin
          ph       = PH_SIZE;
          hdr_open = 1'b0;
          restart_number();
        end
      end
    endcase
    if (seen != 32'hFFFF_FFFF) seen++;

    if (last) begin
      // A packet that ends inside the count or type header takes the digits so far.
      if (ph == PH_COUNT) begin
        decl_fields = acc;
        kind        = kind_of(32'd0);
      end else if (ph == PH_TYPE) begin
        kind = kind_of(acc);
      end
      if (seen <= LenDigits) begin
        st = STATUS_TOO_SHORT;
      end else if (seen != decl_len) begin
        st = STATUS_LEN_MISMATCH;
      end else if ({16'd0, fields} != decl_fields) begin
        st = STATUS_COUNT_MISMATCH;
      end else begin
        st = STATUS_OK;
      end
      r.packet_done = 1'b1;
      r.packet_ok   = (st == STATUS_OK);
      r.status_code = st;
      r.packet_kind = (st == STATUS_TOO_SHORT || st == STATUS_LEN_MISMATCH) ? cfg_undef : kind;
      r.fields_seen = fields;
      last_status = st;
      last_kind   = r.packet_kind;
      status_cnt[st]++;
      rearm();
    end
    if (r.payload_valid || last) deframed_q.insert(deframed_q.size(), r);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) pkt.insert(pkt.size(), s[i]);
  endfunction

  // Prepend the binary length header; a noisy header uses arbitrary bytes for some of the zeros.
  function automatic void put_length(logic [31:0] total, bit noisy);
    logic [7:0] c;
    for (int i = 0; i < LenDigits; i++) begin
      if (total[i]) begin
        c = ASCII_ONE;
      end else if (noisy && $urandom_range(0, 3) == 0) begin
        c = 8'($urandom_range(0, 255));
        if (c == ASCII_ONE) c = 8'h00;
      end else begin
        c = ASCII_ZERO;
      end
      pkt.push_front(c);
    end
  endfunction

  function automatic void add_row(logic [7:0] u, logic [7:0] l, bit raw, int delta,
                                  string text, bit has_exp = 1'b0,
                                  status_e st = STATUS_OK, logic [7:0] k = 8'd0);
    packet_row_t pr;
    pr = '{u, l, raw, delta, text, has_exp, st, k};
    rows.insert(rows.size(), pr);
  endfunction

  // The sender works in bursts of random length separated by random gaps.
  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_byte(b, last);
    burst_left--;
    n_bytes++;
  endtask

  // Send the first count bytes of the packet buffer; the final one carries last_byte.
  task automatic send_packet(int count);
    for (int i = 0; i < count; i++) push_byte(pkt[i], i == count - 1);
  endtask

  // Hold the sender until every expected result has come and the pipeline is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(logic [7:0] u, logic [7:0] l);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_UNDEFINED_TYPE;
    cfg_data_i  <= u;
    @(posedge clk_i);
    cfg_index_i <= CFG_TYPE_LIMIT;
    cfg_data_i  <= l;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_undef = u;
    cfg_limit = l;
    n_cfg++;
  endtask

  // Mostly well-formed packets with random content; the rest are short or pure noise.
  task automatic random_packet();
    int nf;
    int cnt;
    int tval;
    int size;
    int pick;
    int cut;
    logic [31:0] total;
    pkt.delete();
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, LenDigits)) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
    end else if (pick < 22) begin
      repeat ($urandom_range(LenDigits + 1, 70)) begin
        pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
      end
    end else begin
      nf   = $urandom_range(0, 4);
      cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : nf;
      tval = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      put_text($sformatf("%0d/%0d/", cnt, tval));
      for (int f = 0; f < nf; f++) begin
        size = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
        put_text($sformatf("%0d/", size));
        repeat (size) pkt.insert(pkt.size(), 8'($urandom_range(0, 255)));
      end
      total = pkt.size() + LenDigits;
      case ($urandom_range(0, 19))
        0:       total = $urandom();
        1:       total = total + 32'd1;
        2:       total = total - 32'd1;
        default: ;
      endcase
      put_length(total, $urandom_range(0, 9) == 0);
    end
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, pkt.size()) : pkt.size();
    send_packet(cut);
  endtask

  // Receiver: check each result transaction, then pick the next ready on a stall pattern.
  ready_mode_e stall_mode = RDY_ALWAYS;
  int mode_left = 0;
  int ready_cycle = 0;

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {payload_valid_o, payload_byte_o, field_index_o, field_first_o, packet_done_o,
             packet_ok_o, status_code_o, packet_kind_o, fields_seen_o};
      n_results++;
      if (deframed_q.size() == 0) begin
        report_error({"unexpected result ", show(got)});
      end else begin
        want = deframed_q.pop_front();
        if (got !== want) report_error({"expected ", show(want), " got ", show(got)});
      end
    end
    if (mode_left == 0) begin
      stall_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(16, 160);
    end
    mode_left--;
    ready_cycle++;
    case (stall_mode)
      RDY_ALWAYS: out_ready_i <= 1'b1;
      RDY_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready_i <= ($urandom_range(0, 4) == 0);
      default:    out_ready_i <= ((ready_cycle % 9) < 2);
    endcase
  end

  initial begin
    int start;
    cfg_undef = UNDEFINED_TYPE_RESET;
    cfg_limit = TYPE_LIMIT_RESET;
    rearm();

    // Directed packets: status extremes, headers cut short, number parsing, type range.
    add_row(0, 16, 1, 0, "1", 1, STATUS_TOO_SHORT, 0);
    add_row(0, 16, 1, 0, "00000000000000000000000000000000", 1, STATUS_TOO_SHORT, 0);
    add_row(0, 16, 0, 0, "2/5/3/abc2/xy", 1, STATUS_OK, 5);
    add_row(0, 16, 0, 1, "2/5/3/abc2/xy", 1, STATUS_LEN_MISMATCH, 0);
    add_row(0, 16, 0, 0, "3/5/1/a", 1, STATUS_COUNT_MISMATCH, 5);
    add_row(0, 16, 0, -1, "/", 1, STATUS_LEN_MISMATCH, 0);
    add_row(3, 10, 0, 0, "12", 1, STATUS_COUNT_MISMATCH, 3);
    add_row(3, 10, 0, 0, "0/7", 1, STATUS_OK, 7);
    add_row(3, 10, 0, 0, "1/10/2/zz", 1, STATUS_OK, 3);
    add_row(3, 10, 0, 0, "0/9/", 1, STATUS_OK, 9);
    add_row(3, 10, 0, 0, "0/2/", 1, STATUS_OK, 3);
    add_row(3, 10, 0, 0, "1/4/12", 1, STATUS_OK, 4);
    add_row(3, 10, 0, 0, "1/4/10/abc", 1, STATUS_OK, 4);
    add_row(0, 16, 0, 0, "1x9/2/3a5/qrs", 1, STATUS_OK, 2);
    add_row(0, 16, 0, 0, "1//3/abc//");
    add_row(0, 16, 0, 0, "1/1/99999999999/ab");
    add_row(0, 16, 0, 0, "2/1/0/2/hi");
    add_row(255, 0, 0, 0, "0/0/", 1, STATUS_OK, 255);
    add_row(0, 255, 0, 0, "0/254/", 1, STATUS_OK, 254);
    add_row(0, 255, 0, 0, "0/300/", 1, STATUS_OK, 0);
    add_row(255, 255, 0, 0, "0/255/", 1, STATUS_OK, 255);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_config(UNDEFINED_TYPE_RESET, TYPE_LIMIT_RESET);

    foreach (rows[i]) begin
      if (rows[i].undef_type != cfg_undef || rows[i].type_limit != cfg_limit) begin
        set_config(rows[i].undef_type, rows[i].type_limit);
      end
      pkt.delete();
      put_text(rows[i].text);
      if (!rows[i].raw) put_length(pkt.size() + LenDigits + rows[i].len_delta, 1'b0);
      send_packet(pkt.size());
      if (rows[i].has_exp &&
          (last_status != rows[i].exp_status || last_kind != rows[i].exp_kind)) begin
        report_error($sformatf("row %0d: status %0d kind %0d, table has %0d kind %0d", i,
                               last_status, last_kind, rows[i].exp_status, rows[i].exp_kind));
      end
    end

    // Random packets, with occasional configuration changes between them.
    start = n_bytes;
    while (n_bytes < start + RandomBytes) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       set_config(8'd0, 8'd255);
          1:       set_config(8'd255, 8'd0);
          default: set_config(8'($urandom_range(0, 8)), 8'($urandom_range(4, 24)));
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      random_packet();
    end

    in_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("summary: %0d bytes sent, %0d result transactions checked, %0d config updates",
             n_bytes, n_results, n_cfg);
    $display("summary: packets ok %0d, too short %0d, length mismatch %0d, count mismatch %0d",
             status_cnt[STATUS_OK], status_cnt[STATUS_TOO_SHORT],
             status_cnt[STATUS_LEN_MISMATCH], status_cnt[STATUS_COUNT_MISMATCH]);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
